// ===== sv/pont_pkg.sv =====
// ----------------------------------------------------------------------------
// pont_pkg
// Shared types, codes and helpers for the priority ordered name table.
// ----------------------------------------------------------------------------
package pont_pkg;

  // Default table capacity
  localparam int unsigned DefTableDepth = 16;

  // Fixed field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned PrioW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned RemW    = 5;

  // Operation codes
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_FIND   = 2'd2;
  localparam logic [OpW-1:0] OP_DUMP   = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd3;

  // Signed priority compare: a <= b
  function automatic logic prio_le(input logic signed [PrioW-1:0] a,
                                   input logic signed [PrioW-1:0] b);
    return (a <= b);
  endfunction

endpackage

// ===== sv/priority_ordered_name_table_core.sv =====
// Full-table insert and any operation on an empty table give one result
// the cycle after the transfer. Otherwise a scan of up to the n valid slots runs through
// the single table read port, one slot per cycle, before the result is formed.
// Dump gives one result per cycle once its scan has started. A new command is taken
// the cycle after the final result is formed; results cannot be stalled.
// Reset clears the fill count and the sequencer; table contents are not cleared.
// ----------------------------------------------------------------------------
// priority_ordered_name_table_core
// Sorted table of (key, priority) entries with insert, delete, find and dump,
// worked through a table memory with one write and one read port under a small sequencer.
// ----------------------------------------------------------------------------
module priority_ordered_name_table_core
  import pont_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command side
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OpW-1:0]           op_i,
  input  logic [KeyW-1:0]          key_i,
  input  logic signed [PrioW-1:0]  prio_i,
  // result side
  output logic                     result_valid_o,
  output logic [StatusW-1:0]       status_o,
  output logic [KeyW-1:0]          out_key_o,
  output logic signed [PrioW-1:0]  out_prio_o,
  output logic [PosW-1:0]          position_o,
  output logic [RemW-1:0]          removed_o,
  output logic                     last_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [OpW-1:0]          op_q, op_d;
  logic [KeyW-1:0]         key_q, key_d;
  logic signed [PrioW-1:0] prio_q, prio_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [IdxW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]         rd_left_q, rd_left_d;
  logic [IdxW-1:0]         cur_q, cur_d;
  logic                    rv_q, rv_d;
  logic [CntW-1:0]         keep_q, keep_d;

  // Table memory
  logic [KeyW-1:0]         mem_key  [TABLE_DEPTH];
  logic signed [PrioW-1:0] mem_prio [TABLE_DEPTH];
  logic [KeyW-1:0]         rd_key_q;
  logic signed [PrioW-1:0] rd_prio_q;

  logic                    mem_we, mem_re;
  logic [IdxW-1:0]         mem_waddr, mem_raddr;
  logic [KeyW-1:0]         mem_wkey;
  logic signed [PrioW-1:0] mem_wprio;

  // Result being formed this cycle
  logic                    res_valid;
  logic [StatusW-1:0]      res_status;
  logic [KeyW-1:0]         res_key;
  logic signed [PrioW-1:0] res_prio;
  logic [IdxW-1:0]         res_pos;
  logic [CntW-1:0]         res_removed;
  logic                    res_last;

  // Scan helpers
  logic                    is_last;
  logic [CntW-1:0]         kept;
  logic [IdxW-1:0]         cur_next;

  assign busy_o   = (state_q != S_IDLE);
  assign is_last  = (cur_q == IdxW'(fill_q - CntW'(1)));
  assign cur_next = cur_q + IdxW'(1);
  assign kept     = keep_q + ((rd_key_q != key_q) ? CntW'(1) : CntW'(0));

  // Sequencer and memory port control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    prio_d      = prio_q;
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    rd_left_d   = rd_left_q;
    cur_d       = cur_q;
    keep_d      = keep_q;

    mem_we      = 1'b0;
    mem_waddr   = cur_next;
    mem_wkey    = rd_key_q;
    mem_wprio   = rd_prio_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q;

    res_valid   = 1'b0;
    res_status  = ST_OK;
    res_key     = '0;
    res_prio    = '0;
    res_pos     = '0;
    res_removed = '0;
    res_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d   = op_i;
          key_d  = key_i;
          prio_d = prio_i;
          keep_d = '0;
          if (op_i == OP_INSERT) begin
            if (fill_q == CntW'(TABLE_DEPTH)) begin
              res_valid  = 1'b1;
              res_status = ST_FULL;
            end else if (fill_q == '0) begin
              // first entry goes straight to slot zero
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wkey  = key_i;
              mem_wprio = prio_i;
              fill_d    = CntW'(1);
              res_valid = 1'b1;
            end else begin
              // scan from the tail downward, shifting up as we go
              state_d   = S_SCAN;
              rd_ptr_d  = IdxW'(fill_q - CntW'(1));
              rd_left_d = fill_q;
            end
          end else begin
            if (fill_q == '0) begin
              res_valid  = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              state_d   = S_SCAN;
              rd_ptr_d  = '0;
              rd_left_d = fill_q;
            end
          end
        end
      end

      S_SCAN: begin
        // issue the next slot read
        if (rd_left_q != '0) begin
          mem_re    = 1'b1;
          rd_left_d = rd_left_q - CntW'(1);
          cur_d     = rd_ptr_q;
          rd_ptr_d  = (op_q == OP_INSERT) ? (rd_ptr_q - IdxW'(1)) : (rd_ptr_q + IdxW'(1));
        end
        // handle the slot read last cycle
        if (rv_q) begin
          case (op_q)
            OP_INSERT: begin
              mem_we = 1'b1;
              if (prio_le(rd_prio_q, prio_q)) begin
                mem_wkey  = key_q;
                mem_wprio = prio_q;
                fill_d    = fill_q + CntW'(1);
                res_valid = 1'b1;
                res_pos   = cur_next;
                state_d   = S_IDLE;
              end else if (cur_q == '0) begin
                state_d = S_HEAD;
              end
            end
            OP_DELETE: begin
              if (rd_key_q != key_q) begin
                mem_we    = 1'b1;
                mem_waddr = IdxW'(keep_q);
                keep_d    = keep_q + CntW'(1);
              end
              if (is_last) begin
                fill_d      = kept;
                res_valid   = 1'b1;
                res_removed = fill_q - kept;
                res_status  = (kept != fill_q) ? ST_OK : ST_NOT_FOUND;
                state_d     = S_IDLE;
              end
            end
            OP_FIND: begin
              if (rd_key_q == key_q) begin
                res_valid = 1'b1;
                res_key   = rd_key_q;
                res_prio  = rd_prio_q;
                res_pos   = cur_q;
                state_d   = S_IDLE;
              end else if (is_last) begin
                res_valid  = 1'b1;
                res_status = ST_NOT_FOUND;
                state_d    = S_IDLE;
              end
            end
            OP_DUMP: begin
              res_valid = 1'b1;
              res_key   = rd_key_q;
              res_prio  = rd_prio_q;
              res_pos   = cur_q;
              res_last  = is_last;
              if (is_last) begin
                state_d = S_IDLE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_HEAD: begin
        // new entry has the lowest priority so far
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wkey  = key_q;
        mem_wprio = prio_q;
        fill_d    = fill_q + CntW'(1);
        res_valid = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rv_d = mem_re && (state_d == S_SCAN);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fill_q         <= '0;
      rv_q           <= 1'b0;
      rd_left_q      <= '0;
      keep_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      fill_q         <= fill_d;
      rv_q           <= rv_d;
      rd_left_q      <= rd_left_d;
      keep_q         <= keep_d;
      result_valid_o <= res_valid;
    end
  end

  // Command and scan payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    prio_q   <= prio_d;
    rd_ptr_q <= rd_ptr_d;
    cur_q    <= cur_d;
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_o   <= res_status;
      out_key_o  <= res_key;
      out_prio_o <= res_prio;
      position_o <= PosW'(res_pos);
      removed_o  <= RemW'(res_removed);
      last_o     <= res_last;
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_key[mem_waddr]  <= mem_wkey;
      mem_prio[mem_waddr] <= mem_wprio;
    end
    if (mem_re) begin
      rd_key_q  <= mem_key[mem_raddr];
      rd_prio_q <= mem_prio[mem_raddr];
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // a result follows either a running scan or a command answered at once
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o || start_i))
    else $error("result without a command in flight");

  a_final_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("sequencer still busy after final result");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CntW'(mem_waddr) <= fill_q))
    else $error("table write beyond the fill count");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !rv_q)
    else $error("slot read pending while idle");

endmodule

// ===== verif/priority_ordered_name_table_checker.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_name_table_checker
// Watches the command and result ports of the name table, keeps its own copy
// of the sorted table, and compares every result strobe with the oldest
// expected result. Hands the mismatch count and the number of outstanding
// results to the testbench top.
// ----------------------------------------------------------------------------
module priority_ordered_name_table_checker
  import pont_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command side
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [OpW-1:0]           op_i,
  input  logic [KeyW-1:0]          key_i,
  input  logic signed [PrioW-1:0]  prio_i,
  // result side
  input  logic                     result_valid_i,
  input  logic [StatusW-1:0]       status_i,
  input  logic [KeyW-1:0]          out_key_i,
  input  logic signed [PrioW-1:0]  out_prio_i,
  input  logic [PosW-1:0]          position_i,
  input  logic [RemW-1:0]          removed_i,
  input  logic                     last_i,
  // to the top
  output int unsigned              err_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [StatusW-1:0]      status;
    logic [KeyW-1:0]         key;
    logic signed [PrioW-1:0] prio;
    logic [PosW-1:0]         position;
    logic [RemW-1:0]         removed;
    logic                    last;
  } table_result_t;

  // Shadow table, kept sorted by ascending priority
  logic [KeyW-1:0]         shadow_key  [TABLE_DEPTH];
  logic signed [PrioW-1:0] shadow_prio [TABLE_DEPTH];
  int unsigned             shadow_fill = 0;

  table_result_t expected_results[$];
  int unsigned   mismatches  = 0;
  int unsigned   outstanding = 0;

  assign err_count_o = mismatches;
  assign pending_o   = outstanding;

  function automatic table_result_t pack_result(input logic [StatusW-1:0] st,
                                                input logic [KeyW-1:0] k,
                                                input logic signed [PrioW-1:0] p,
                                                input int unsigned pos,
                                                input int unsigned rem,
                                                input logic lst);
    table_result_t r;
    r.status   = st;
    r.key      = k;
    r.prio     = p;
    r.position = pos[PosW-1:0];
    r.removed  = rem[RemW-1:0];
    r.last     = lst;
    return r;
  endfunction

  // Apply one command to the shadow table and queue the results it causes
  task automatic apply_table_cmd(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                                 input logic signed [PrioW-1:0] prio);
    int unsigned slot;
    int unsigned keep;
    int unsigned idx;
    slot = 0;
    keep = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= TABLE_DEPTH) begin
          expected_results.push_back(pack_result(ST_FULL, '0, '0, 0, 0, 1'b1));
        end else begin
          // new entry goes after every entry of lower or equal priority
          while (slot < shadow_fill && shadow_prio[slot] <= prio) slot++;
          idx = shadow_fill;
          while (idx > slot) begin
            shadow_key[idx]  = shadow_key[idx-1];
            shadow_prio[idx] = shadow_prio[idx-1];
            idx--;
          end
          shadow_key[slot]  = key;
          shadow_prio[slot] = prio;
          shadow_fill++;
          expected_results.push_back(pack_result(ST_OK, '0, '0, slot, 0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (shadow_fill == 0) begin
          expected_results.push_back(pack_result(ST_EMPTY, '0, '0, 0, 0, 1'b1));
        end else begin
          // compact the survivors toward slot 0
          for (idx = 0; idx < shadow_fill; idx++) begin
            if (shadow_key[idx] != key) begin
              shadow_key[keep]  = shadow_key[idx];
              shadow_prio[keep] = shadow_prio[idx];
              keep++;
            end
          end
          expected_results.push_back(pack_result((keep == shadow_fill) ? ST_NOT_FOUND : ST_OK,
                                                 '0, '0, 0, shadow_fill - keep, 1'b1));
          shadow_fill = keep;
        end
      end
      OP_FIND: begin
        if (shadow_fill == 0) begin
          expected_results.push_back(pack_result(ST_EMPTY, '0, '0, 0, 0, 1'b1));
        end else begin
          while (slot < shadow_fill && shadow_key[slot] != key) slot++;
          if (slot < shadow_fill)
            expected_results.push_back(pack_result(ST_OK, shadow_key[slot], shadow_prio[slot],
                                                   slot, 0, 1'b1));
          else
            expected_results.push_back(pack_result(ST_NOT_FOUND, '0, '0, 0, 0, 1'b1));
        end
      end
      default: begin
        // dump: one result per entry, last flag on the final one
        if (shadow_fill == 0) begin
          expected_results.push_back(pack_result(ST_EMPTY, '0, '0, 0, 0, 1'b1));
        end else begin
          for (idx = 0; idx < shadow_fill; idx++)
            expected_results.push_back(pack_result(ST_OK, shadow_key[idx], shadow_prio[idx],
                                                   idx, 0, idx + 1 == shadow_fill));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare one result strobe with the oldest expectation
  task automatic compare_result();
    table_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d key %h prio %h",
               $time, status_i, out_key_i, out_prio_i);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("status",   64'(want.status),   64'(status_i));
      check_field("out_key",  want.key,           out_key_i);
      check_field("out_prio", 64'(want.prio),     64'(out_prio_i));
      check_field("position", 64'(want.position), 64'(position_i));
      check_field("removed",  64'(want.removed),  64'(removed_i));
      check_field("last",     64'(want.last),     64'(last_i));
    end
  endtask

  // Results of earlier commands are retired before a new transfer is predicted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (result_valid_i) compare_result();
      if (start_i && !busy_i) apply_table_cmd(op_i, key_i, prio_i);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== verif/priority_ordered_name_table_core_test.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_name_table_core_test
// Drives insert, delete, find and dump commands into the name table: a
// directed run over the empty, full, tie and extreme-priority cases, then
// random traffic that alternates between filling and draining the table.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module priority_ordered_name_table_core_test
  import pont_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH  = DefTableDepth;
  localparam int unsigned RANDOM_ITEMS = 135;
  localparam int unsigned QUIET_TAIL   = 30;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                    clk_i    = 1'b0;
  logic                    rst_ni   = 1'b0;
  logic                    start_i  = 1'b0;
  logic [OpW-1:0]          op_i     = OP_INSERT;
  logic [KeyW-1:0]         key_i    = '0;
  logic signed [PrioW-1:0] prio_i   = '0;
  logic                    busy_o;
  logic                    result_valid_o;
  logic [StatusW-1:0]      status_o;
  logic [KeyW-1:0]         out_key_o;
  logic signed [PrioW-1:0] out_prio_o;
  logic [PosW-1:0]         position_o;
  logic [RemW-1:0]         removed_o;
  logic                    last_o;

  int unsigned     err_count;
  int unsigned     pending;
  int unsigned     stall_cycles = 0;
  logic [KeyW-1:0] key_pool [8];

  always #10 clk_i = ~clk_i;

  priority_ordered_name_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .key_i, .prio_i,
    .result_valid_o, .status_o, .out_key_o, .out_prio_o, .position_o,
    .removed_o, .last_o
  );

  priority_ordered_name_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) table_check (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .key_i, .prio_i,
    .result_valid_i(result_valid_o), .status_i(status_o), .out_key_i(out_key_o),
    .out_prio_i(out_prio_o), .position_i(position_o), .removed_i(removed_o),
    .last_i(last_o), .err_count_o(err_count), .pending_o(pending)
  );

  // Watchdog: cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("priority_ordered_name_table_core_test: done, errors");
      $finish;
    end
  end

  // One command transfer; start stays high until the caller lowers it
  task automatic issue_cmd(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                           input logic signed [PrioW-1:0] prio);
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i    <= op;
    key_i   <= key;
    prio_i  <= prio;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    repeat (cycles) @(negedge clk_i) start_i <= 1'b0;
  endtask

  // Hold off until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i) start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  // Mix of extremes, ties and full-range priorities
  function automatic logic signed [PrioW-1:0] pick_prio();
    int signed near;
    near = $urandom_range(6);
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      2: return near - 3;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [PrioW-1:0] dir_prio [16];
    logic [KeyW-1:0]         dir_key;
    logic [OpW-1:0]          op_sel;
    int unsigned             roll;
    int unsigned             idx;
    bit                      filling;

    dir_prio = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 0, -1, 5, 5, 5,
                 -100, 100, 0, -1, 32'sh7fff_ffff, 32'sh8000_0000, 3, 3};
    foreach (key_pool[p]) key_pool[p] = {$urandom, $urandom};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty table, fill to capacity with ties and extremes
    issue_cmd(OP_FIND,   key_pool[0], '0);
    issue_cmd(OP_DELETE, key_pool[0], '0);
    issue_cmd(OP_DUMP,   '0,          '0);
    for (idx = 0; idx < 16; idx++) begin
      if (idx < 8)       dir_key = key_pool[idx];
      else if (idx == 8) dir_key = '0;
      else if (idx == 9) dir_key = '1;
      else               dir_key = key_pool[idx % 3];
      issue_cmd(OP_INSERT, dir_key, dir_prio[idx]);
    end
    // full table, hit and miss, dump all, multi-match delete, missed delete
    issue_cmd(OP_INSERT, key_pool[5], 32'sd7);
    issue_cmd(OP_FIND,   key_pool[1], '0);
    issue_cmd(OP_FIND,   {$urandom, $urandom}, '0);
    issue_cmd(OP_DUMP,   '0, '0);
    issue_cmd(OP_DELETE, key_pool[0], '0);
    issue_cmd(OP_DELETE, {$urandom, $urandom}, '0);
    wait_drained();

    // Random: alternate fill-heavy and drain-heavy stretches
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx % 50 == 25) wait_drained();
      filling = (idx % 40) < 26;
      roll    = $urandom_range(99);
      if (roll < (filling ? 65 : 20))      op_sel = OP_INSERT;
      else if (roll < (filling ? 75 : 65)) op_sel = OP_DELETE;
      else if (roll < (filling ? 90 : 88)) op_sel = OP_FIND;
      else                                 op_sel = OP_DUMP;
      issue_cmd(op_sel, pick_key(), pick_prio());
      if (idx < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
        idle_gap($urandom_range(1, 5));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0)
      $display("priority_ordered_name_table_core_test: done, clean");
    else
      $display("priority_ordered_name_table_core_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pont_pkg.sv
sv/priority_ordered_name_table_core.sv
verif/priority_ordered_name_table_checker.sv
verif/priority_ordered_name_table_core_test.sv
